@@ hw/rtl/fwips_pkg.sv @@
// Package for the four-wheel incremental PID speed controller: constants, codes and types.
package fwips_pkg;

  localparam int NUM_MOTORS     = 4;
  localparam int MOTOR_W        = 2;
  localparam int OP_W           = 2;
  localparam int CNT_W          = 14;
  localparam int AIM_W          = 13;
  localparam int DIST_W         = 16;
  localparam int REV_W          = 16;
  localparam int TALLY_W        = 16;
  localparam int ERR_W          = 14;
  localparam int GAIN_W         = 16;
  localparam int DUTY_W         = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam int PULSES_PER_REV = 1024;
  localparam int WHEEL_STEP     = 200;
  localparam int FRAC_BITS      = 8;

  localparam int ACC_W          = DUTY_W + FRAC_BITS;
  localparam int D1_W           = ERR_W + 1;
  localparam int D2_W           = ERR_W + 2;
  localparam int MUL_W          = GAIN_W + 1 + D2_W;
  localparam int SUM_W          = MUL_W + 2;

  // Division by the wheel step as a multiply by a rounded-up reciprocal.
  // With the shift at the operand width plus ceil(log2(step)) the quotient
  // is exact for every 16-bit distance magnitude.
  localparam int              DIV_SHIFT = DIST_W + $clog2(WHEEL_STEP);
  localparam longint unsigned RECIP     =
      ((64'd1 << DIV_SHIFT) + WHEEL_STEP - 1) / WHEEL_STEP;
  localparam int              PROD_W    = DIV_SHIFT + REV_W;

  localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = GAIN_W'(148);
  localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = GAIN_W'(563);
  localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = GAIN_W'(205);
  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = DUTY_W'(250);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_SPEED = 2'd1,
    OP_MOVE  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP  = 2'd0,
    REG_GAIN_INTEG = 2'd1,
    REG_GAIN_DERIV = 2'd2,
    REG_DUTY_LIMIT = 2'd3
  } reg_idx_t;

  // One row of the per-motor history memory.
  typedef struct packed {
    logic signed [ERR_W-1:0] err_last;
    logic signed [ERR_W-1:0] err_prev;
    logic [REV_W-1:0]        revs;
    logic [TALLY_W-1:0]      tally;
  } row_t;

endpackage

@@ hw/rtl/four_wheel_incremental_pid_speed.sv @@
// Top level of the four-wheel incremental PID speed controller.
//
// Each input word is a control tick, a single-motor speed set or a move
// command; only a control tick returns an output word (motor, duty,
// direction, reached flag). The block sustains one input word per clock
// cycle while the output is not stalled, including ticks for the same
// motor back to back. A tick's result word is registered at the output:
// stage 1 reads the motor's error and revolution history from the history
// memory and updates position tracking, stage 2 forms the three gain
// products, and stage 3 reads the duty accumulator memory, adds and
// clamps. Same-motor reads that collide with a write in flight are served
// by forwarding registers. Speed sets and move commands take effect as they
// leave stage 1 and return nothing. A result word waiting at the
// output does not block new input words until all pipeline stages are full.
// No clearing pass is needed after reset: per-motor valid flags make unwritten
// memory rows read as zero, and a move command drops the revolution flags.
module four_wheel_incremental_pid_speed
  import fwips_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [OP_W-1:0]              in_op,
  input  logic [MOTOR_W-1:0]           in_motor_index,
  input  logic signed [CNT_W-1:0]      in_encoder_count,
  input  logic signed [AIM_W-1:0]      in_aim_value,
  input  logic signed [DIST_W-1:0]     in_move_distance,
  input  logic signed [AIM_W-1:0]      in_move_speed,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [MOTOR_W-1:0]           out_motor,
  output logic [DUTY_W-1:0]            out_duty,
  output logic                         out_dir_forward,
  output logic                         out_target_reached,

  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  // Configuration registers.
  logic [GAIN_W-1:0] gain_prop_r, gain_integ_r, gain_deriv_r;
  logic [DUTY_W-1:0] duty_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r  <= GAIN_PROP_RST;
      gain_integ_r <= GAIN_INTEG_RST;
      gain_deriv_r <= GAIN_DERIV_RST;
      duty_limit_r <= DUTY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_PROP:  gain_prop_r  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEG: gain_integ_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIV: gain_deriv_r <= cfg_data[GAIN_W-1:0];
        REG_DUTY_LIMIT: duty_limit_r <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control. Each stage moves forward when the next one is empty
  // or moving itself, so bubbles close up behind a stalled output.
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic s1_go, s2_go, s3_go, s1_is_tick, in_fire, row_we;

  assign s3_go      = s3_vld_r && (!out_vld_r || out_ready);
  assign s2_go      = s2_vld_r && (!s3_vld_r || s3_go);
  assign s1_go      = s1_vld_r && (!s1_is_tick || !s2_vld_r || s2_go);
  assign in_ready   = !s1_vld_r || s1_go;
  assign in_fire    = in_valid && in_ready;
  assign row_we     = s1_go && s1_is_tick;

  // Stage 1 registers: the accepted word and the history row read with it.
  logic [OP_W-1:0]          s1_op_r;
  logic [MOTOR_W-1:0]       s1_motor_r;
  logic signed [CNT_W-1:0]  s1_cnt_r;
  logic signed [AIM_W-1:0]  s1_aim_r;
  logic signed [DIST_W-1:0] s1_dist_r;
  logic signed [AIM_W-1:0]  s1_spd_r;
  row_t                     row_rd_r, row_fwd_r, row_wdata;
  logic                     row_hit_r;

  row_t                     row_mem [NUM_MOTORS];
  logic [NUM_MOTORS-1:0]    err_vld_r, pos_vld_r;
  logic signed [AIM_W-1:0]  aim_r [NUM_MOTORS];
  logic [REV_W-1:0]         target_revs_r;

  assign s1_is_tick = (s1_op_r == OP_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_go) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_op;
      s1_motor_r <= in_motor_index;
      s1_cnt_r   <= in_encoder_count;
      s1_aim_r   <= in_aim_value;
      s1_dist_r  <= in_move_distance;
      s1_spd_r   <= in_move_speed;
      row_rd_r   <= row_mem[in_motor_index];
      // The memory returns the old row when it is written in the same cycle.
      row_hit_r  <= row_we && (s1_motor_r == in_motor_index);
      row_fwd_r  <= row_wdata;
    end
    if (row_we) begin
      row_mem[s1_motor_r] <= row_wdata;
    end
  end

  // Stage 1 logic: position tracking, error terms and move decoding.
  row_t                     row_cur;
  logic signed [ERR_W-1:0]  e1_old, e2_old, e_cur;
  logic [REV_W-1:0]         revs_old, revs_inc, revs_new;
  logic [TALLY_W-1:0]       tally_old, tally_new;
  logic [TALLY_W:0]         tally_sum;
  logic [CNT_W-1:0]         cnt_mag;
  logic signed [AIM_W-1:0]  aim_cur;
  logic [AIM_W-1:0]         aim_mag, aim_eff_mag;
  logic signed [ERR_W:0]    e_wide;
  logic signed [D1_W-1:0]   d1;
  logic signed [D2_W-1:0]   d2;
  logic                     pos_on, wrap, reached, dir_fwd;
  logic [DIST_W-1:0]        dist_mag;
  logic [PROD_W-1:0]        quot_prod;
  logic [REV_W-1:0]         target_nxt;
  logic                     dist_pos;
  logic signed [AIM_W-1:0]  spd_neg, aim_even_nxt, aim_odd_nxt;

  always_comb begin
    row_cur   = row_hit_r ? row_fwd_r : row_rd_r;
    e1_old    = err_vld_r[s1_motor_r] ? row_cur.err_last : '0;
    e2_old    = err_vld_r[s1_motor_r] ? row_cur.err_prev : '0;
    revs_old  = pos_vld_r[s1_motor_r] ? row_cur.revs : '0;
    tally_old = pos_vld_r[s1_motor_r] ? row_cur.tally : '0;

    cnt_mag   = s1_cnt_r[CNT_W-1] ? CNT_W'(-s1_cnt_r) : CNT_W'(s1_cnt_r);
    pos_on    = (target_revs_r != '0);
    tally_sum = {1'b0, tally_old} + (TALLY_W+1)'(cnt_mag);
    wrap      = (tally_sum >= (TALLY_W+1)'(PULSES_PER_REV));
    revs_inc  = (wrap && (revs_old != {REV_W{1'b1}})) ? revs_old + 1'b1 : revs_old;
    revs_new  = pos_on ? revs_inc : revs_old;
    tally_new = pos_on ? (wrap ? '0 : tally_sum[TALLY_W-1:0]) : tally_old;
    reached   = pos_on && (revs_new >= target_revs_r);

    // Reaching the target zeroes this motor's aim speed in the error and clears every aim speed as the tick retires.
    aim_cur     = aim_r[s1_motor_r];
    aim_mag     = aim_cur[AIM_W-1] ? AIM_W'(-aim_cur) : AIM_W'(aim_cur);
    aim_eff_mag = reached ? '0 : aim_mag;
    dir_fwd     = !reached && !aim_cur[AIM_W-1] && (aim_cur != '0);

    e_wide = $signed({2'b00, aim_eff_mag}) - $signed({1'b0, cnt_mag});
    e_cur  = e_wide[ERR_W-1:0];
    d1     = D1_W'(e_cur) - D1_W'(e1_old);
    d2     = D2_W'(e_cur) - (D2_W'(e1_old) <<< 1) + D2_W'(e2_old);

    row_wdata.err_last = e_cur;
    row_wdata.err_prev = e1_old;
    row_wdata.revs     = revs_new;
    row_wdata.tally    = tally_new;

    // Move command decode.
    dist_mag   = s1_dist_r[DIST_W-1] ? DIST_W'(-s1_dist_r) : DIST_W'(s1_dist_r);
    quot_prod  = PROD_W'(dist_mag) * PROD_W'(RECIP);
    target_nxt = quot_prod[DIV_SHIFT +: REV_W];
    dist_pos   = !s1_dist_r[DIST_W-1] && (s1_dist_r != '0);
    // Negating the most negative speed saturates to the largest positive one.
    spd_neg    = (s1_spd_r == {1'b1, {(AIM_W-1){1'b0}}}) ?
                 {1'b0, {(AIM_W-1){1'b1}}} : -s1_spd_r;
    aim_even_nxt = dist_pos ? spd_neg : s1_spd_r;
    aim_odd_nxt  = dist_pos ? s1_spd_r : spd_neg;
  end

  // Per-motor aim speeds, target and valid flags change as stage 1 retires.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
        aim_r[k] <= '0;
      end
      target_revs_r <= '0;
      err_vld_r     <= '0;
      pos_vld_r     <= '0;
    end else if (s1_go) begin
      case (s1_op_r)
        OP_TICK: begin
          err_vld_r[s1_motor_r] <= 1'b1;
          pos_vld_r[s1_motor_r] <= 1'b1;
          if (reached) begin
            for (int k = 0; k < NUM_MOTORS; k++) begin
              aim_r[k] <= '0;
            end
          end
        end
        OP_SPEED: begin
          aim_r[s1_motor_r] <= s1_aim_r;
        end
        OP_MOVE: begin
          target_revs_r <= target_nxt;
          pos_vld_r     <= '0;
          for (int k = 0; k < NUM_MOTORS; k++) begin
            aim_r[k] <= k[0] ? aim_odd_nxt : aim_even_nxt;
          end
        end
        default: ;
      endcase
    end
  end

  // Stage 2: error terms waiting for the gain products.
  logic [MOTOR_W-1:0]      s2_motor_r;
  logic signed [ERR_W-1:0] s2_e_r;
  logic signed [D1_W-1:0]  s2_d1_r;
  logic signed [D2_W-1:0]  s2_d2_r;
  logic                    s2_dir_r, s2_reached_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (row_we) begin
      s2_vld_r <= 1'b1;
    end else if (s2_go) begin
      s2_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      s2_motor_r   <= s1_motor_r;
      s2_e_r       <= e_cur;
      s2_d1_r      <= d1;
      s2_d2_r      <= d2;
      s2_dir_r     <= dir_fwd;
      s2_reached_r <= reached;
    end
  end

  logic signed [MUL_W-1:0] p_nxt, i_nxt, d_nxt;

  always_comb begin
    p_nxt = MUL_W'($signed({1'b0, gain_prop_r}))  * MUL_W'(s2_d1_r);
    i_nxt = MUL_W'($signed({1'b0, gain_integ_r})) * MUL_W'(s2_e_r);
    d_nxt = MUL_W'($signed({1'b0, gain_deriv_r})) * MUL_W'(s2_d2_r);
  end

  // Stage 3: products plus the accumulator read from its memory.
  logic [MOTOR_W-1:0]      s3_motor_r;
  logic signed [MUL_W-1:0] s3_p_r, s3_i_r, s3_d_r;
  logic                    s3_dir_r, s3_reached_r;
  logic [ACC_W-1:0]        acc_mem [NUM_MOTORS];
  logic [ACC_W-1:0]        acc_rd_r, acc_fwd_r, acc_new;
  logic                    acc_hit_r, acc_ok_r;
  logic [NUM_MOTORS-1:0]   acc_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s2_go) begin
      s3_vld_r <= 1'b1;
    end else if (s3_go) begin
      s3_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (s3_go) begin
      acc_vld_r[s3_motor_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_motor_r   <= s2_motor_r;
      s3_p_r       <= p_nxt;
      s3_i_r       <= i_nxt;
      s3_d_r       <= d_nxt;
      s3_dir_r     <= s2_dir_r;
      s3_reached_r <= s2_reached_r;
      acc_rd_r     <= acc_mem[s2_motor_r];
      acc_hit_r    <= s3_go && (s3_motor_r == s2_motor_r);
      acc_fwd_r    <= acc_new;
      acc_ok_r     <= acc_vld_r[s2_motor_r];
    end
    if (s3_go) begin
      acc_mem[s3_motor_r] <= acc_new;
    end
  end

  logic [ACC_W-1:0]        acc_old, acc_top;
  logic signed [SUM_W-1:0] acc_sum;

  always_comb begin
    acc_old = acc_hit_r ? acc_fwd_r : (acc_ok_r ? acc_rd_r : '0);
    acc_top = {duty_limit_r, {FRAC_BITS{1'b0}}};
    acc_sum = SUM_W'(s3_p_r) + SUM_W'(s3_i_r) + SUM_W'(s3_d_r)
            + $signed(SUM_W'(acc_old));
    if (acc_sum < 0) begin
      acc_new = '0;
    end else if (acc_sum > $signed(SUM_W'(acc_top))) begin
      acc_new = acc_top;
    end else begin
      acc_new = acc_sum[ACC_W-1:0];
    end
  end

  // Output register.
  logic [MOTOR_W-1:0] out_motor_r;
  logic [DUTY_W-1:0]  out_duty_r;
  logic               out_dir_r, out_reached_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s3_go) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go) begin
      out_motor_r   <= s3_motor_r;
      out_duty_r    <= acc_new[ACC_W-1:FRAC_BITS];
      out_dir_r     <= s3_dir_r;
      out_reached_r <= s3_reached_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_motor          = out_motor_r;
  assign out_duty           = out_duty_r;
  assign out_dir_forward    = out_dir_r;
  assign out_target_reached = out_reached_r;

  // A written accumulator never leaves the clamp range.
  a_acc_clamped : assert property (@(posedge clk) disable iff (!rst_n)
    s3_go |-> (acc_new <= acc_top))
    else $error("accumulator written above the duty limit");

  // The pulse tally stays below one revolution.
  a_tally_range : assert property (@(posedge clk) disable iff (!rst_n)
    row_we |-> (row_wdata.tally < TALLY_W'(PULSES_PER_REV)))
    else $error("pulse tally reached a full revolution");

  // A move command drops all revolution history.
  a_move_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_op_r == OP_MOVE)) |=> (pos_vld_r == '0))
    else $error("revolution history survived a move command");

  // A result that reports the target reached never reports forward motion.
  a_reached_stop : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_reached_r) |-> !out_dir_r)
    else $error("reached result reports forward motion");

endmodule
